// ===== design/bmp24_pkg.sv =====
package bmp24_pkg;

    localparam int unsigned HEADER_BYTES  = 54;
    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int unsigned MIN_INFO_SIZE = 40;
    localparam int unsigned MAX_DEPTH     = 32;
    localparam int unsigned PIXEL_DEPTH   = 24;
    localparam int unsigned ROUND_UP      = 31;

    typedef logic [3:0] status_t;

    localparam status_t ST_PIXEL      = 4'd0;
    localparam status_t ST_SIGNATURE  = 4'd1;
    localparam status_t ST_HEADER     = 4'd2;
    localparam status_t ST_DEPTH      = 4'd3;
    localparam status_t ST_DIMENSION  = 4'd4;
    localparam status_t ST_SHORT      = 4'd5;
    localparam status_t ST_NOT_24BPP  = 4'd6;
    localparam status_t ST_EARLY_END  = 4'd7;
    localparam status_t ST_BAD_OFFSET = 4'd8;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_PIXEL  = 4'b0100,
        PH_IDLE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [12:0] width;
        logic [12:0] height;
        logic [31:0] offset;
        logic [13:0] stride;
    } hdr_info_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] width;
        logic [12:0] height;
        logic        final_res;
    } result_t;

endpackage

// ===== design/bmp24_in_reg.sv =====
module bmp24_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bmp24_pkg::item_t item_in,
    input  logic             ready,
    output logic             fire,
    output bmp24_pkg::item_t item_q
);
    import bmp24_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  load;

    assign fire     = valid_reg && ready;
    assign in_stall = valid_reg && !ready;
    assign load     = in_valid && !in_stall;
    assign item_q   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// ===== design/bmp24_hdr.sv =====
module bmp24_hdr (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [5:0]           pos,
    input  logic [7:0]           data,
    input  logic [31:0]          file_length,
    output bmp24_pkg::hdr_info_t info
);
    import bmp24_pkg::*;

    localparam logic [5:0] POS_SIG0  = 6'd0;
    localparam logic [5:0] POS_SIG1  = 6'd1;
    localparam logic [5:0] POS_OFF   = 6'd10;
    localparam logic [5:0] POS_DIB   = 6'd14;
    localparam logic [5:0] POS_WIDTH = 6'd18;
    localparam logic [5:0] POS_HGT   = 6'd22;
    localparam logic [5:0] POS_DIMS  = 6'd26;
    localparam logic [5:0] POS_BPP   = 6'd28;
    localparam logic [5:0] POS_COMP  = 6'd30;
    localparam logic [5:0] POS_NEED  = 6'd31;

    logic [7:0]  sig0_reg;
    logic [7:0]  sig1_reg;
    logic [31:0] off_reg;
    logic [31:0] dib_reg;
    logic [31:0] width_reg;
    logic [31:0] height_reg;
    logic [15:0] bpp_reg;
    logic [31:0] comp_reg;
    logic        dims_bad_reg;
    logic [12:0] habs_reg;
    logic [15:0] stride_reg;
    logic [28:0] need_reg;

    logic [31:0] habs_full;
    logic        dims_bad_next;
    logic [18:0] bits_per_row;
    logic [15:0] stride_next;
    logic [31:0] room;

    function automatic logic in_field(input logic [5:0] p, input logic [5:0] first);
        in_field = (p >= first) && (p <= first + 6'd3);
    endfunction

    // negative height means a top-down file, taken by magnitude
    assign habs_full = height_reg[31] ? (~height_reg + 32'd1) : height_reg;

    assign dims_bad_next = width_reg[31] || (width_reg == 32'd0) ||
                           (width_reg > 32'(MAX_DIMENSION)) ||
                           (height_reg == 32'd0) || (habs_full > 32'(MAX_DIMENSION));

    // stride in bytes, rounded up to a 32-bit boundary
    assign bits_per_row = 19'(width_reg[12:0] * bpp_reg[5:0]) + 19'(ROUND_UP);
    assign stride_next  = {bits_per_row[18:5], 2'b00};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (pos == POS_SIG0)
            begin
                sig0_reg <= data;
            end
            if (pos == POS_SIG1)
            begin
                sig1_reg <= data;
            end
            if (in_field(pos, POS_OFF))
            begin
                off_reg <= {data, off_reg[31:8]};
            end
            if (in_field(pos, POS_DIB))
            begin
                dib_reg <= {data, dib_reg[31:8]};
            end
            if (in_field(pos, POS_WIDTH))
            begin
                width_reg <= {data, width_reg[31:8]};
            end
            if (in_field(pos, POS_HGT))
            begin
                height_reg <= {data, height_reg[31:8]};
            end
            if ((pos == POS_BPP) || (pos == POS_BPP + 6'd1))
            begin
                bpp_reg <= {data, bpp_reg[15:8]};
            end
            if (in_field(pos, POS_COMP))
            begin
                comp_reg <= {data, comp_reg[31:8]};
            end
            if (pos == POS_DIMS)
            begin
                dims_bad_reg <= dims_bad_next;
                habs_reg     <= habs_full[12:0];
            end
            if (pos == POS_COMP)
            begin
                stride_reg <= stride_next;
            end
            if (pos == POS_NEED)
            begin
                need_reg <= 29'(stride_reg * habs_reg);
            end
        end
    end

    assign room = file_length - off_reg;

    always_comb
    begin
        info.width  = width_reg[12:0];
        info.height = habs_reg;
        info.offset = off_reg;
        info.stride = stride_reg[13:0];
        if ((sig0_reg != 8'h42) || (sig1_reg != 8'h4D))
        begin
            info.status = ST_SIGNATURE;
        end
        else if ((dib_reg < 32'(MIN_INFO_SIZE)) || (comp_reg != 32'd0))
        begin
            info.status = ST_HEADER;
        end
        else if ((bpp_reg == 16'd0) || (bpp_reg > 16'(MAX_DEPTH)))
        begin
            info.status = ST_DEPTH;
        end
        else if (dims_bad_reg)
        begin
            info.status = ST_DIMENSION;
        end
        else if ((file_length < off_reg) || (room < {3'b000, need_reg}))
        begin
            info.status = ST_SHORT;
        end
        else if (bpp_reg != 16'(PIXEL_DEPTH))
        begin
            info.status = ST_NOT_24BPP;
        end
        else if (off_reg < 32'(HEADER_BYTES))
        begin
            info.status = ST_BAD_OFFSET;
        end
        else
        begin
            info.status = ST_PIXEL;
        end
    end

endmodule

// ===== design/bmp24_ctrl.sv =====
module bmp24_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  bmp24_pkg::item_t     item,
    input  bmp24_pkg::hdr_info_t info,
    output logic                 hdr_wr,
    output logic [5:0]           hdr_pos,
    output logic                 res_load,
    output bmp24_pkg::result_t   result
);
    import bmp24_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [31:0] pos_reg,    pos_next;
    logic [13:0] byte_reg,   byte_next;
    logic [1:0]  trip_reg,   trip_next;
    logic [12:0] col_reg,    col_next;
    logic [11:0] row_reg,    row_next;
    logic [7:0]  blue_reg,   blue_next;
    logic [7:0]  green_reg,  green_next;
    logic [12:0] pic_w_reg,  pic_w_next;
    logic [12:0] pic_h_reg,  pic_h_next;
    logic [31:0] off_reg,    off_next;
    logic [13:0] stride_reg, stride_next;

    logic [31:0] pos_inc;
    logic [13:0] byte_inc;
    logic        last_hdr;
    logic        fin;

    assign hdr_wr   = fire && (phase_reg == PH_HEADER);
    assign hdr_pos  = pos_reg[5:0];
    assign pos_inc  = pos_reg + 32'd1;
    assign byte_inc = byte_reg + 14'd1;
    assign last_hdr = (pos_reg[5:0] == 6'(HEADER_BYTES - 1));
    assign fin      = ((13'(row_reg) + 13'd1) >= pic_h_reg) &&
                      ((col_reg + 13'd1) >= pic_w_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        byte_next   = byte_reg;
        trip_next   = trip_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        pic_w_next  = pic_w_reg;
        pic_h_next  = pic_h_reg;
        off_next    = off_reg;
        stride_next = stride_reg;
        res_load    = 1'b0;
        result      = '0;
        if (fire)
        begin
            pos_next = pos_inc;
            case (phase_reg)
                PH_HEADER:
                begin
                    if (last_hdr)
                    begin
                        if (info.status != ST_PIXEL)
                        begin
                            result.status    = info.status;
                            result.final_res = 1'b1;
                            res_load         = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            pic_w_next  = info.width;
                            pic_h_next  = info.height;
                            off_next    = info.offset;
                            stride_next = info.stride;
                            if (info.offset == 32'(HEADER_BYTES))
                            begin
                                phase_next = PH_PIXEL;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (pos_inc >= off_reg)
                    begin
                        phase_next = PH_PIXEL;
                    end
                end
                PH_PIXEL:
                begin
                    // padding bytes past the last column are dropped
                    if (col_reg < pic_w_reg)
                    begin
                        case (trip_reg)
                            2'd0:
                            begin
                                blue_next = item.data;
                            end
                            2'd1:
                            begin
                                green_next = item.data;
                            end
                            default:
                            begin
                                result.status    = ST_PIXEL;
                                result.column    = col_reg[11:0];
                                result.row       = 12'(pic_h_reg - 13'd1 - 13'(row_reg));
                                result.red       = item.data;
                                result.green     = green_reg;
                                result.blue      = blue_reg;
                                result.width     = pic_w_reg;
                                result.height    = pic_h_reg;
                                result.final_res = fin;
                                res_load         = 1'b1;
                                if (fin)
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        endcase
                    end
                    if (byte_inc >= stride_reg)
                    begin
                        byte_next = '0;
                        trip_next = '0;
                        col_next  = '0;
                        row_next  = row_reg + 12'd1;
                    end
                    else
                    begin
                        byte_next = byte_inc;
                        if (trip_reg == 2'd2)
                        begin
                            trip_next = '0;
                            col_next  = col_reg + 13'd1;
                        end
                        else
                        begin
                            trip_next = trip_reg + 2'd1;
                        end
                    end
                end
                PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
            if (item.last)
            begin
                // unfinished image at end of stream
                if ((phase_reg != PH_IDLE) && (phase_next != PH_IDLE))
                begin
                    result           = '0;
                    result.status    = ST_EARLY_END;
                    result.width     = pic_w_next;
                    result.height    = pic_h_next;
                    result.final_res = 1'b1;
                    res_load         = 1'b1;
                end
                phase_next  = PH_HEADER;
                pos_next    = '0;
                byte_next   = '0;
                trip_next   = '0;
                col_next    = '0;
                row_next    = '0;
                blue_next   = '0;
                green_next  = '0;
                pic_w_next  = '0;
                pic_h_next  = '0;
                off_next    = '0;
                stride_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            byte_reg   <= '0;
            trip_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            pic_w_reg  <= '0;
            pic_h_reg  <= '0;
            off_reg    <= '0;
            stride_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            byte_reg   <= byte_next;
            trip_reg   <= trip_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            pic_w_reg  <= pic_w_next;
            pic_h_reg  <= pic_h_next;
            off_reg    <= off_next;
            stride_reg <= stride_next;
        end
    end

endmodule

// ===== design/bmp24_out_reg.sv =====
module bmp24_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bmp24_pkg::result_t result_in,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               ready,
    output bmp24_pkg::result_t result_q
);
    import bmp24_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign out_valid = valid_reg;
    assign ready     = !valid_reg || !out_stall;
    assign result_q  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

// ===== design/bmp24_to_rgba_decoder_core.sv =====
// result path: input register, parse state update, result register, in that order
// throughput: one file byte per cycle while the output is not stalled, set by the update of the
//   parse state on every accepted byte between the input register and the result register
// reset: rst_n clears the parse state to the header phase, all counters to zero,
//   file_length to zero and both handshake registers to empty
module bmp24_to_rgba_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [11:0] dest_column,
    output logic [11:0] dest_row,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [12:0] image_width,
    output logic [12:0] image_height,
    output logic        final_res
);
    import bmp24_pkg::*;

    logic [31:0] file_length_reg;
    item_t       item_in;
    item_t       item_q;
    logic        fire;
    logic        ready;
    logic        hdr_wr;
    logic [5:0]  hdr_pos;
    hdr_info_t   info;
    logic        res_load;
    result_t     result;
    result_t     result_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            file_length_reg <= cfg_wr_data;
        end
    end

    assign item_in.data = file_byte;
    assign item_in.last = end_of_file;

    bmp24_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .item_in  (item_in),
        .ready    (ready),
        .fire     (fire),
        .item_q   (item_q)
    );

    bmp24_hdr u_hdr (
        .clk         (clk),
        .wr_en       (hdr_wr),
        .pos         (hdr_pos),
        .data        (item_q.data),
        .file_length (file_length_reg),
        .info        (info)
    );

    bmp24_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_q),
        .info     (info),
        .hdr_wr   (hdr_wr),
        .hdr_pos  (hdr_pos),
        .res_load (res_load),
        .result   (result)
    );

    bmp24_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .result_in (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .ready     (ready),
        .result_q  (result_q)
    );

    assign status       = result_q.status;
    assign dest_column  = result_q.column;
    assign dest_row     = result_q.row;
    assign red          = result_q.red;
    assign green        = result_q.green;
    assign blue         = result_q.blue;
    assign image_width  = result_q.width;
    assign image_height = result_q.height;
    assign final_res    = result_q.final_res;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import bmp24_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_SLACK    = 6;
    localparam int unsigned TOTAL_BYTES    = 1700;
    localparam bit [15:0]   BMP_MAGIC      = 16'h4D42;

    typedef enum {LEN_KEEP, LEN_EXACT, LEN_GIVEN} len_mode_t;

    typedef struct {
        bit [15:0] sig;
        bit [31:0] off;
        bit [31:0] dib;
        bit [31:0] w;
        bit [31:0] h;
        bit [31:0] comp;
        bit [15:0] bpp;
        len_mode_t len_mode;
        int        len_adj;
        bit [31:0] flen;
        int        extra;
        int        cut;
        int        pause_at;
        int        hold_at;
    } file_desc_t;

    class bmp_decode_scoreboard;
        result_t     pending_pixels[$];
        int unsigned fail_count;
        bit [31:0]   file_len;
        phase_t      phase;
        bit [7:0]    hdr[HEADER_BYTES];
        bit [31:0]   position;
        bit [13:0]   stride;
        bit [13:0]   byte_in_row;
        bit [11:0]   stored_row;
        bit [7:0]    held_b;
        bit [7:0]    held_g;
        bit [12:0]   pic_w;
        bit [12:0]   pic_h;
        bit [31:0]   pix_off;

        function new();
            fail_count = 0;
            file_len = 0;
            foreach (hdr[i])
                hdr[i] = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_HEADER;
            position = 0;
            stride = 0;
            byte_in_row = 0;
            stored_row = 0;
            held_b = 0;
            held_g = 0;
            pic_w = 0;
            pic_h = 0;
            pix_off = 0;
        endfunction

        function void set_length(bit [31:0] v);
            file_len = v;
        endfunction

        function int unsigned pending();
            return pending_pixels.size();
        endfunction

        function bit [31:0] le32(int at);
            return {hdr[at + 3], hdr[at + 2], hdr[at + 1], hdr[at]};
        endfunction

        function status_t judge_header();
            bit [31:0] off;
            bit [31:0] dib;
            bit [31:0] wu;
            bit [31:0] hu;
            bit [31:0] comp;
            bit [31:0] habs;
            bit [15:0] bpp;
            bit [63:0] strd;
            bit [63:0] need;
            if ({hdr[1], hdr[0]} != BMP_MAGIC)
                return ST_SIGNATURE;
            off = le32(10);
            dib = le32(14);
            wu = le32(18);
            hu = le32(22);
            bpp = {hdr[29], hdr[28]};
            comp = le32(30);
            if (dib < MIN_INFO_SIZE || comp != 0)
                return ST_HEADER;
            if (bpp == 0 || bpp > MAX_DEPTH)
                return ST_DEPTH;
            if (wu[31] || wu == 0 || wu > MAX_DIMENSION)
                return ST_DIMENSION;
            habs = hu[31] ? -hu : hu;
            if (hu == 0 || habs > MAX_DIMENSION)
                return ST_DIMENSION;
            strd = (({32'b0, wu} * bpp + ROUND_UP) / 32) * 4;
            need = strd * habs;
            if (file_len < off || {32'b0, file_len - off} < need)
                return ST_SHORT;
            if (bpp != PIXEL_DEPTH)
                return ST_NOT_24BPP;
            if (off < HEADER_BYTES)
                return ST_BAD_OFFSET;
            pic_w = wu[12:0];
            pic_h = habs[12:0];
            pix_off = off;
            stride = strd[13:0];
            return ST_PIXEL;
        endfunction

        // predicts the result of one accepted byte transaction
        function void note_byte(bit [7:0] fbyte, bit eof);
            result_t     r;
            bit          have;
            bit          was_active;
            bit [31:0]   p;
            status_t     st;
            int unsigned b;
            int unsigned col;
            r = '0;
            have = 0;
            was_active = (phase != PH_IDLE);
            p = position;
            position = p + 1;
            case (phase)
                PH_HEADER:
                begin
                    if (p < HEADER_BYTES)
                        hdr[p] = fbyte;
                    if (p + 1 >= HEADER_BYTES)
                    begin
                        st = judge_header();
                        if (st != ST_PIXEL)
                        begin
                            pic_w = 0;
                            pic_h = 0;
                            r.status = st;
                            r.final_res = 1;
                            have = 1;
                            phase = PH_IDLE;
                        end
                        else
                            phase = (pix_off == HEADER_BYTES) ? PH_PIXEL : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (p + 1 >= pix_off)
                        phase = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    b = byte_in_row;
                    if (b < 3 * pic_w)
                    begin
                        if (b % 3 == 0)
                            held_b = fbyte;
                        else if (b % 3 == 1)
                            held_g = fbyte;
                        else
                        begin
                            col = b / 3;
                            r.status = ST_PIXEL;
                            r.column = col[11:0];
                            r.row = 12'(pic_h - 1 - stored_row);
                            r.red = fbyte;
                            r.green = held_g;
                            r.blue = held_b;
                            r.width = pic_w;
                            r.height = pic_h;
                            r.final_res = (stored_row + 1 >= pic_h) && (col + 1 >= pic_w);
                            have = 1;
                            if (r.final_res)
                                phase = PH_IDLE;
                        end
                    end
                    b++;
                    if (b >= stride)
                    begin
                        b = 0;
                        stored_row++;
                    end
                    byte_in_row = b[13:0];
                end
                default:
                    ;
            endcase
            if (eof)
            begin
                if (was_active && phase != PH_IDLE)
                begin
                    r = '0;
                    r.status = ST_EARLY_END;
                    r.width = pic_w;
                    r.height = pic_h;
                    r.final_res = 1;
                    have = 1;
                end
                restart();
            end
            if (have)
                pending_pixels.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: st=%0d col=%0d row=%0d fin=%0b",
                             got.status, got.column, got.row, got.final_res);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.status != want.status || got.column != want.column ||
                got.row != want.row || got.red != want.red ||
                got.green != want.green || got.blue != want.blue ||
                got.width != want.width || got.height != want.height ||
                got.final_res != want.final_res)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display({"mismatch exp: st=%0d col=%0d row=%0d rgb=%02h%02h%02h",
                              " w=%0d h=%0d fin=%0b"},
                             want.status, want.column, want.row, want.red, want.green,
                             want.blue, want.width, want.height, want.final_res);
                    $display({"         got: st=%0d col=%0d row=%0d rgb=%02h%02h%02h",
                              " w=%0d h=%0d fin=%0b"},
                             got.status, got.column, got.row, got.red, got.green,
                             got.blue, got.width, got.height, got.final_res);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  file_byte = '0;
    logic        end_of_file = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  status;
    logic [11:0] dest_column;
    logic [11:0] dest_row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        final_res;

    bit steady = 0;
    bit hold_req = 0;

    bmp_decode_scoreboard sb = new();

    bmp24_to_rgba_decoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .file_byte    (file_byte),
        .end_of_file  (end_of_file),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .dest_column  (dest_column),
        .dest_row     (dest_row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .image_width  (image_width),
        .image_height (image_height),
        .final_res    (final_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver side: random stall, with one long hold-off on request
    initial
    begin
        int unsigned hold_cnt;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                hold_cnt = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < 33);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result({status, dest_column, dest_row, red, green, blue,
                                 image_width, image_height, final_res});
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    function automatic void put_le(ref bit [7:0] q[$], input int at, input bit [31:0] v,
                                   input int n);
        for (int i = 0; i < n; i++)
            q[at + i] = v[8 * i +: 8];
    endfunction

    function automatic file_desc_t good_file(int unsigned w, int unsigned hh);
        file_desc_t d;
        d.sig = BMP_MAGIC;
        d.off = HEADER_BYTES;
        d.dib = MIN_INFO_SIZE;
        d.w = w;
        d.h = hh;
        d.comp = 0;
        d.bpp = PIXEL_DEPTH;
        d.len_mode = LEN_EXACT;
        d.len_adj = 0;
        d.flen = 0;
        d.extra = 0;
        d.cut = 0;
        d.pause_at = -1;
        d.hold_at = -1;
        return d;
    endfunction

    function automatic file_desc_t random_file();
        file_desc_t  d;
        int unsigned w;
        int unsigned hh;
        int unsigned pick;
        w = ($urandom_range(19) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
        hh = $urandom_range(1, 4);
        d = good_file(w, hh);
        if ($urandom_range(1))
            d.h = 0 - hh;
        if ($urandom_range(2) == 0)
            d.off = HEADER_BYTES + $urandom_range(1, 6);
        if ($urandom_range(3) == 0)
            d.dib = MIN_INFO_SIZE + $urandom_range(1, 100);
        d.extra = $urandom_range(3);
        if ($urandom_range(9) == 0)
        begin
            d.len_mode = LEN_GIVEN;
            d.flen = 32'hFFFF_FFFF;
        end
        pick = $urandom_range(99);
        if (pick < 8)
            d.cut = $urandom_range(1, 90);
        else if (pick < 18)
        begin
            case ($urandom_range(7))
                0: d.sig = 16'($urandom);
                1: d.dib = $urandom;
                2: d.comp = $urandom;
                3: d.bpp = 16'($urandom);
                4: d.w = $urandom;
                5: d.h = $urandom;
                6: d.len_adj = -int'($urandom_range(1, 4));
                default: d.off = $urandom_range(0, 53);
            endcase
        end
        else if (pick < 21)
        begin
            d.sig = ($urandom_range(1)) ? BMP_MAGIC : 16'($urandom);
            d.off = $urandom;
            d.dib = $urandom;
            d.w = $urandom;
            d.h = $urandom;
            d.bpp = 16'($urandom);
            d.comp = $urandom;
        end
        return d;
    endfunction

    task automatic run_file(input file_desc_t d, inout int unsigned sent);
        bit [7:0]    q[$];
        bit [31:0]   habs;
        bit [31:0]   flen;
        bit [63:0]   strd;
        int unsigned body;
        int unsigned gap;
        int unsigned idle;
        int          last;
        habs = d.h[31] ? -d.h : d.h;
        repeat (HEADER_BYTES) q.push_back(8'($urandom_range(255)));
        put_le(q, 0, d.sig, 2);
        put_le(q, 10, d.off, 4);
        put_le(q, 14, d.dib, 4);
        put_le(q, 18, d.w, 4);
        put_le(q, 22, d.h, 4);
        put_le(q, 28, d.bpp, 2);
        put_le(q, 30, d.comp, 4);
        if (d.bpp == PIXEL_DEPTH && d.w >= 1 && d.w <= MAX_DIMENSION &&
            habs >= 1 && habs <= MAX_DIMENSION)
        begin
            strd = ((d.w * PIXEL_DEPTH + ROUND_UP) / 32) * 4;
            body = 32'(strd * habs);
            gap = (d.off > HEADER_BYTES && d.off < 200) ? d.off - HEADER_BYTES : 0;
        end
        else
        begin
            body = $urandom_range(5);
            gap = 0;
        end
        repeat (gap + body + d.extra) q.push_back(8'($urandom_range(255)));
        flen = (d.len_mode == LEN_GIVEN) ? d.flen : q.size() + d.len_adj;
        if (d.cut > 0 && d.cut < q.size())
            q = q[0:d.cut - 1];
        last = q.size() - 1;

        wait_drained();
        if (d.len_mode != LEN_KEEP)
        begin
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= flen;
            @(posedge clk);
            sb.set_length(flen);
            cfg_wr_en <= 1'b0;
        end

        for (int i = 0; i <= last; i++)
        begin
            idle = 0;
            if (!steady)
                while ($urandom_range(99) < 33)
                    idle++;
            if (i == d.pause_at)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            else if (idle > 0)
            begin
                in_valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            if (i == d.hold_at)
                hold_req = 1;
            in_valid <= 1'b1;
            file_byte <= q[i];
            end_of_file <= (i == last);
            do
                @(posedge clk);
            while (in_stall);
            sb.note_byte(q[i], i == last);
            sent++;
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        file_desc_t  d;
        int unsigned sent;
        int unsigned nfile;
        sent = 0;
        nfile = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // length register still at its reset value
        d = good_file(2, 2);
        d.len_mode = LEN_KEEP;
        run_file(d, sent);

        d = good_file(1, 1); d.sig = 16'h4D41; run_file(d, sent);
        d = good_file(1, 1); d.sig = 16'h4C42; run_file(d, sent);
        d = good_file(1, 1); d.dib = MIN_INFO_SIZE - 1; run_file(d, sent);
        d = good_file(1, 1); d.comp = 1; run_file(d, sent);
        d = good_file(1, 1); d.bpp = 0; run_file(d, sent);
        d = good_file(1, 1); d.bpp = MAX_DEPTH + 1; run_file(d, sent);
        d = good_file(1, 1); d.w = 0; run_file(d, sent);
        d = good_file(1, 1); d.w = MAX_DIMENSION + 1; run_file(d, sent);
        d = good_file(1, 1); d.w = 32'hFFFF_FFFF; run_file(d, sent);
        d = good_file(1, 1); d.h = 0; run_file(d, sent);
        d = good_file(1, 1); d.h = MAX_DIMENSION + 1; run_file(d, sent);
        d = good_file(1, 1); d.h = 0 - (MAX_DIMENSION + 1); run_file(d, sent);
        d = good_file(2, 2); d.len_mode = LEN_GIVEN; d.flen = 0; run_file(d, sent);
        d = good_file(2, 2); d.len_adj = -1; run_file(d, sent);
        d = good_file(2, 2); d.off = 1000; d.len_mode = LEN_GIVEN; d.flen = 500;
        run_file(d, sent);
        d = good_file(3, 2); d.bpp = 1; d.len_mode = LEN_GIVEN; d.flen = 32'hFFFF_FFFF;
        run_file(d, sent);
        d = good_file(3, 2); d.bpp = MAX_DEPTH; d.len_mode = LEN_GIVEN;
        d.flen = 32'hFFFF_FFFF;
        run_file(d, sent);
        d = good_file(2, 1); d.off = HEADER_BYTES - 1; d.len_mode = LEN_GIVEN;
        d.flen = 32'hFFFF_FFFF;
        run_file(d, sent);
        d = good_file(2, 1); d.off = 0; run_file(d, sent);

        d = good_file(1, 1); run_file(d, sent);
        d = good_file(3, 2); d.h = 0 - 2; d.off = HEADER_BYTES + 6; d.extra = 5;
        d.len_mode = LEN_GIVEN; d.flen = 32'hFFFF_FFFF;
        run_file(d, sent);
        d = good_file(MAX_DIMENSION, 1); d.cut = 120; d.hold_at = 80; run_file(d, sent);
        d = good_file(1, MAX_DIMENSION); d.cut = 120; d.pause_at = 90; run_file(d, sent);

        // end of stream in each phase, also after a finished image, no idling on either side
        steady = 1;
        d = good_file(2, 2); d.cut = 1; run_file(d, sent);
        d = good_file(2, 2); d.cut = 30; run_file(d, sent);
        d = good_file(2, 2); d.cut = HEADER_BYTES; run_file(d, sent);
        d = good_file(2, 2); d.off = HEADER_BYTES + 6; d.cut = HEADER_BYTES + 3;
        run_file(d, sent);
        d = good_file(2, 2); d.cut = HEADER_BYTES + 3; run_file(d, sent);
        d = good_file(2, 2); d.cut = HEADER_BYTES + 4; run_file(d, sent);
        d = good_file(2, 2); d.extra = 3; run_file(d, sent);
        steady = 0;

        while (sent < TOTAL_BYTES || nfile < 3)
        begin
            d = random_file();
            run_file(d, sent);
            nfile++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== bmp24_to_rgba_decoder_core.f =====
design/bmp24_pkg.sv
design/bmp24_in_reg.sv
design/bmp24_hdr.sv
design/bmp24_ctrl.sv
design/bmp24_out_reg.sv
design/bmp24_to_rgba_decoder_core.sv
tb/tb.sv
